[sv/tlmc_pkg.sv]
// Shared types, codes and helpers for the traffic light mode controller.
`default_nettype none

package tlmc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [15:0] RED_TIME_RST       = 16'd2000;
    localparam logic [15:0] YELLOW_TIME_RST    = 16'd500;
    localparam logic [15:0] GREEN_TIME_RST     = 16'd2000;
    localparam logic [15:0] FLICKER_PERIOD_RST = 16'd142;
    localparam logic [15:0] BLINK_PERIOD_RST   = 16'd500;
    localparam logic [7:0]  DEBOUNCE_TIME_RST  = 8'd200;

    typedef enum logic [2:0] {
        REG_RED_TIME       = 3'd0,
        REG_YELLOW_TIME    = 3'd1,
        REG_GREEN_TIME     = 3'd2,
        REG_FLICKER_PERIOD = 3'd3,
        REG_BLINK_PERIOD   = 3'd4,
        REG_DEBOUNCE_TIME  = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_EMERG  = 3'd1,
        ACT_BLINK  = 3'd2,
        ACT_OFF    = 3'd3,
        ACT_FORCE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_EMERG  = 2'd1,
        MODE_BLINK  = 2'd2,
        MODE_OFF    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_RED  = 3'd0,
        PH_YEL  = 3'd1,
        PH_GRN  = 3'd2,
        PH_FLK  = 3'd3,
        PH_YEL2 = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] yellow_level;
        logic [7:0] green_level;
        mode_t      mode;
        phase_t     phase;
    } result_t;

    // pot*255/1023, truncated. Division by 1023 via x/1023 = (x + (x>>10) + 1) >> 10,
    // exact for every product that a 10-bit sample can give.
    function automatic logic [7:0] pot_to_level(input logic [9:0] pot);
        logic [17:0] prod;
        logic [18:0] acc;
        prod = {pot, 8'd0} - {8'd0, pot};
        acc  = {1'b0, prod} + 19'(prod >> 10) + 19'd1;
        return acc[17:10];
    endfunction

endpackage

`default_nettype wire

[sv/tlmc_regs.sv]
// APB configuration register file for the traffic light mode controller.
`default_nettype none

module tlmc_regs
    import tlmc_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    output logic      [TIME_WIDTH-1:0] red_time,
    output logic      [TIME_WIDTH-1:0] yellow_time,
    output logic      [TIME_WIDTH-1:0] green_time,
    output logic      [TIME_WIDTH-1:0] flicker_period,
    output logic      [TIME_WIDTH-1:0] blink_period,
    output logic      [7:0]            debounce_time
);

    localparam int CW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
    localparam logic [CW-1:0] TIME_MAX = CW'((64'd1 << TIME_WIDTH) - 64'd1);

    // Low 16 bits, clipped to the largest time value
    function automatic logic [TIME_WIDTH-1:0] clip_time(input logic [15:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return TIME_WIDTH'((w > TIME_MAX) ? TIME_MAX : w);
    endfunction

    logic [TIME_WIDTH-1:0] red_time_reg;
    logic [TIME_WIDTH-1:0] yellow_time_reg;
    logic [TIME_WIDTH-1:0] green_time_reg;
    logic [TIME_WIDTH-1:0] flicker_period_reg;
    logic [TIME_WIDTH-1:0] blink_period_reg;
    logic [7:0]            debounce_time_reg;

    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_time_reg       <= clip_time(RED_TIME_RST);
            yellow_time_reg    <= clip_time(YELLOW_TIME_RST);
            green_time_reg     <= clip_time(GREEN_TIME_RST);
            flicker_period_reg <= clip_time(FLICKER_PERIOD_RST);
            blink_period_reg   <= clip_time(BLINK_PERIOD_RST);
            debounce_time_reg  <= DEBOUNCE_TIME_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RED_TIME:       red_time_reg       <= clip_time(pwdata[15:0]);
                REG_YELLOW_TIME:    yellow_time_reg    <= clip_time(pwdata[15:0]);
                REG_GREEN_TIME:     green_time_reg     <= clip_time(pwdata[15:0]);
                REG_FLICKER_PERIOD: flicker_period_reg <= clip_time(pwdata[15:0]);
                REG_BLINK_PERIOD:   blink_period_reg   <= clip_time(pwdata[15:0]);
                REG_DEBOUNCE_TIME:  debounce_time_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RED_TIME:       prdata = DATA_W'(red_time_reg);
            REG_YELLOW_TIME:    prdata = DATA_W'(yellow_time_reg);
            REG_GREEN_TIME:     prdata = DATA_W'(green_time_reg);
            REG_FLICKER_PERIOD: prdata = DATA_W'(flicker_period_reg);
            REG_BLINK_PERIOD:   prdata = DATA_W'(blink_period_reg);
            REG_DEBOUNCE_TIME:  prdata = DATA_W'(debounce_time_reg);
            default:            prdata = '0;
        endcase
    end

    assign red_time       = red_time_reg;
    assign yellow_time    = yellow_time_reg;
    assign green_time     = green_time_reg;
    assign flicker_period = flicker_period_reg;
    assign blink_period   = blink_period_reg;
    assign debounce_time  = debounce_time_reg;

endmodule

`default_nettype wire

[sv/tlmc_core.sv]
// Mode/phase state and combinational update logic of the traffic light mode controller.
`default_nettype none

module tlmc_core
    import tlmc_pkg::*;
#(
    parameter int FLICKER_STEPS = 7,
    parameter int TIME_WIDTH    = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire action_t               action,
    input  wire logic [9:0]            pot_level,
    input  wire logic [TIME_WIDTH-1:0] red_time,
    input  wire logic [TIME_WIDTH-1:0] yellow_time,
    input  wire logic [TIME_WIDTH-1:0] green_time,
    input  wire logic [TIME_WIDTH-1:0] flicker_period,
    input  wire logic [TIME_WIDTH-1:0] blink_period,
    input  wire logic [7:0]            debounce_time,
    output result_t                    result_next
);

    mode_t                 mode_reg, mode_next;
    phase_t                phase_reg, phase_next;
    logic [TIME_WIDTH-1:0] phase_elapsed_reg, phase_elapsed_next;
    logic [2:0]            flicker_cnt_reg, flicker_cnt_next;
    logic                  blink_lit_reg, blink_lit_next;
    logic [TIME_WIDTH-1:0] blink_elapsed_reg, blink_elapsed_next;
    logic [7:0]            since_press_reg, since_press_next;

    logic                  is_press;
    mode_t                 target;
    logic [2:0]            flicker_inc;
    logic [7:0]            level;

    assign flicker_inc = flicker_cnt_reg + 3'd1;
    assign level       = pot_to_level(pot_level);

    always_comb
    begin
        mode_next          = mode_reg;
        phase_next         = phase_reg;
        phase_elapsed_next = phase_elapsed_reg;
        flicker_cnt_next   = flicker_cnt_reg;
        blink_lit_next     = blink_lit_reg;
        blink_elapsed_next = blink_elapsed_reg;
        since_press_next   = since_press_reg;
        is_press           = 1'b0;
        target             = MODE_EMERG;

        unique case (action)
            ACT_TICK:
            begin
                if (since_press_reg != 8'hFF)
                begin
                    since_press_next = since_press_reg + 8'd1;
                end
                if (mode_reg == MODE_NORMAL)
                begin
                    // saturating phase timer
                    if (phase_elapsed_reg != '1)
                    begin
                        phase_elapsed_next = phase_elapsed_reg + TIME_WIDTH'(1);
                    end
                    unique case (phase_reg)
                        PH_RED:
                        begin
                            if (phase_elapsed_next >= red_time)
                            begin
                                phase_next         = PH_YEL;
                                phase_elapsed_next = '0;
                            end
                        end
                        PH_YEL:
                        begin
                            if (phase_elapsed_next >= yellow_time)
                            begin
                                phase_next         = PH_GRN;
                                phase_elapsed_next = '0;
                            end
                        end
                        PH_GRN:
                        begin
                            if (phase_elapsed_next >= green_time)
                            begin
                                phase_next         = PH_FLK;
                                phase_elapsed_next = '0;
                                flicker_cnt_next   = 3'd0;
                            end
                        end
                        PH_FLK:
                        begin
                            if (phase_elapsed_next >= flicker_period)
                            begin
                                phase_elapsed_next = '0;
                                flicker_cnt_next   = flicker_inc;
                                if (flicker_inc >= 3'(FLICKER_STEPS))
                                begin
                                    phase_next = PH_YEL2;
                                end
                            end
                        end
                        default:
                        begin
                            // second yellow
                            if (phase_elapsed_next >= yellow_time)
                            begin
                                phase_next         = PH_RED;
                                phase_elapsed_next = '0;
                            end
                        end
                    endcase
                end
                else if (mode_reg == MODE_BLINK)
                begin
                    if (blink_elapsed_reg != '1)
                    begin
                        blink_elapsed_next = blink_elapsed_reg + TIME_WIDTH'(1);
                    end
                    if (blink_elapsed_next >= blink_period)
                    begin
                        blink_elapsed_next = '0;
                        blink_lit_next     = ~blink_lit_reg;
                    end
                end
            end
            ACT_EMERG:
            begin
                is_press = 1'b1;
                target   = MODE_EMERG;
            end
            ACT_BLINK:
            begin
                is_press = 1'b1;
                target   = MODE_BLINK;
            end
            ACT_OFF:
            begin
                is_press = 1'b1;
                target   = MODE_OFF;
            end
            ACT_FORCE:
            begin
                mode_next          = MODE_NORMAL;
                phase_next         = PH_RED;
                phase_elapsed_next = '0;
                flicker_cnt_next   = 3'd0;
            end
            default: ;
        endcase

        // debounced press: toggle into the target mode or back to normal at red
        if (is_press && (since_press_reg >= debounce_time))
        begin
            since_press_next = 8'd0;
            if (mode_reg == target)
            begin
                mode_next          = MODE_NORMAL;
                phase_next         = PH_RED;
                phase_elapsed_next = '0;
                flicker_cnt_next   = 3'd0;
            end
            else
            begin
                mode_next = target;
                if (target == MODE_BLINK)
                begin
                    blink_lit_next     = ~blink_lit_reg;
                    blink_elapsed_next = '0;
                end
            end
        end
    end

    // lamp drive from the updated state
    always_comb
    begin
        result_next.red_level    = 8'd0;
        result_next.yellow_level = 8'd0;
        result_next.green_level  = 8'd0;
        result_next.mode         = mode_next;
        result_next.phase        = phase_next;
        unique case (mode_next)
            MODE_NORMAL:
            begin
                priority if (phase_next == PH_RED)
                begin
                    result_next.red_level = level;
                end
                else if (phase_next == PH_YEL || phase_next == PH_YEL2)
                begin
                    result_next.yellow_level = level;
                end
                else if (phase_next == PH_GRN)
                begin
                    result_next.green_level = level;
                end
                else
                begin
                    // flicker: lit on even interval counts
                    if (!flicker_cnt_next[0])
                    begin
                        result_next.green_level = level;
                    end
                end
            end
            MODE_EMERG:
            begin
                result_next.red_level = level;
            end
            MODE_BLINK:
            begin
                if (blink_lit_next)
                begin
                    result_next.red_level    = level;
                    result_next.yellow_level = level;
                    result_next.green_level  = level;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_NORMAL;
            phase_reg         <= PH_RED;
            phase_elapsed_reg <= '0;
            flicker_cnt_reg   <= 3'd0;
            blink_lit_reg     <= 1'b0;
            blink_elapsed_reg <= '0;
            since_press_reg   <= 8'd0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            phase_reg         <= phase_next;
            phase_elapsed_reg <= phase_elapsed_next;
            flicker_cnt_reg   <= flicker_cnt_next;
            blink_lit_reg     <= blink_lit_next;
            blink_elapsed_reg <= blink_elapsed_next;
            since_press_reg   <= since_press_next;
        end
    end

endmodule

`default_nettype wire

[sv/traffic_light_mode_controller_top.sv]
// Top level of the traffic light mode controller: transfer stages, core and registers.
//
// Usage:
//  - Input channel (in_valid/in_stall, action, pot_level) carries one item per
//    transfer: a one-millisecond tick, a mode press (emergency, blink, off) or a
//    force-normal command, each with a potentiometer sample for brightness.
//  - Output channel (out_valid/out_stall) returns exactly one result per item:
//    three lamp levels, the current mode and the current normal-mode phase.
//  - Timing registers are written over the APB port (byte address 4*index);
//    write them only while no item is in flight.
//  - Order: an item taken from the input channel is held in the input
//    register; when it advances it updates the state and its result is
//    captured in the result register at that same edge, raising out_valid.
//  - Throughput: one item per clock while no result is held by out_stall. The
//    state update is narrow counter logic between the input and result registers.
//  - Stall: when out_stall holds a result and the input register is also
//    full, in_stall rises; otherwise a new item is taken while a finished
//    result waits.
//  - Reset (rst_n, async, low): normal mode, red phase, all timers cleared,
//    registers back to their defaults, both stages empty.
`default_nettype none

module traffic_light_mode_controller_top
    import tlmc_pkg::*;
#(
    parameter int FLICKER_STEPS = 7,
    parameter int TIME_WIDTH    = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        action,
    input  wire logic [9:0]        pot_level,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [7:0]        red_level,
    output logic      [7:0]        yellow_level,
    output logic      [7:0]        green_level,
    output logic      [1:0]        mode,
    output logic      [2:0]        phase,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [2:0]            action_reg;
    logic [9:0]            pot_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    result_t               result_reg;
    result_t               result_next;

    logic                  in_take;
    logic                  advance;

    logic [TIME_WIDTH-1:0] red_time;
    logic [TIME_WIDTH-1:0] yellow_time;
    logic [TIME_WIDTH-1:0] green_time;
    logic [TIME_WIDTH-1:0] flicker_period;
    logic [TIME_WIDTH-1:0] blink_period;
    logic [7:0]            debounce_time;

    // The held item moves on whenever the result register is free or draining.
    assign advance      = in_vld_reg & (~out_vld_reg | ~out_stall);
    assign in_stall     = in_vld_reg & out_vld_reg & out_stall;
    assign in_take      = in_valid & ~in_stall;
    assign in_vld_next  = in_take | (in_vld_reg & ~advance);
    assign out_vld_next = advance | (out_vld_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            pot_reg    <= pot_level;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    tlmc_regs #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .red_time       (red_time),
        .yellow_time    (yellow_time),
        .green_time     (green_time),
        .flicker_period (flicker_period),
        .blink_period   (blink_period),
        .debounce_time  (debounce_time)
    );

    tlmc_core #(
        .FLICKER_STEPS (FLICKER_STEPS),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .action         (action_t'(action_reg)),
        .pot_level      (pot_reg),
        .red_time       (red_time),
        .yellow_time    (yellow_time),
        .green_time     (green_time),
        .flicker_period (flicker_period),
        .blink_period   (blink_period),
        .debounce_time  (debounce_time),
        .result_next    (result_next)
    );

    assign out_valid    = out_vld_reg;
    assign red_level    = result_reg.red_level;
    assign yellow_level = result_reg.yellow_level;
    assign green_level  = result_reg.green_level;
    assign mode         = result_reg.mode;
    assign phase        = result_reg.phase;

    // Off mode keeps every lamp dark.
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result_reg.mode == MODE_OFF) |->
            (result_reg.red_level == 8'd0 && result_reg.yellow_level == 8'd0 &&
             result_reg.green_level == 8'd0))
        else $error("lamp lit in off mode");

    // Emergency drives red only.
    a_emerg_red: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result_reg.mode == MODE_EMERG) |->
            (result_reg.yellow_level == 8'd0 && result_reg.green_level == 8'd0))
        else $error("non-red lamp lit in emergency mode");

    // Normal mode never lights two lamps at once.
    a_normal_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result_reg.mode == MODE_NORMAL) |->
            ($countones({result_reg.red_level != 8'd0, result_reg.yellow_level != 8'd0,
                         result_reg.green_level != 8'd0}) <= 1))
        else $error("more than one lamp lit in normal mode");

    // Blink mode switches all three lamps together.
    a_blink_same: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result_reg.mode == MODE_BLINK) |->
            (result_reg.red_level == result_reg.yellow_level &&
             result_reg.red_level == result_reg.green_level))
        else $error("blink lamps out of step");

endmodule

`default_nettype wire
